// File: src/rmth_pkg.sv
package rmth_pkg;

   localparam int CAPACITY_DEF    = 1024;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int MEDIAN_BITS     = 33;
   localparam int COUNT_BITS      = 11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_OP_START,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_NEXT_OP,
      ST_TOPS,
      ST_RESULT
   } state_type;

   // One heap operation: push a value or replace the root.
   typedef struct packed {
      logic go;
      logic replace;
      logic sel_upper;
   } heap_cmd_type;

   // True when a must sit above b in the heap.
   function automatic logic ranks_above(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic               max_heap);
      ranks_above = max_heap ? (a > b) : (a < b);
   endfunction

endpackage

// File: src/rmth_heap_mem.sv
module rmth_heap_mem import rmth_pkg::*; #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [31:0]       wr_data,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output logic [31:0]       rd_data_a,
   output logic [31:0]       rd_data_b
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: src/running_median_two_heaps.sv
// Streaming median over a two-heap store.
// Input channel req_valid/req_ready/req_sample carries one signed sample per
// beat. Result channel rsp_valid/rsp_ready carries rsp_twice_median (twice the
// median, so an odd value means a half), rsp_stored_count and rsp_dropped.
// Every accepted sample gives exactly one result beat.
// An item runs through a sequencer that drives one compare-and-swap unit over
// two heap memories, each with two registered read ports. Each sift level is a
// read state and a compare state. A push climbs level by level, and a
// replace-root sinks level by level. A step with a rebalance adds a second
// operation. A dropped sample (store full) skips the heap operations. The sift
// loop is what sets how long an item takes.
// The block takes one item at a time: req_ready is high only when idle and no
// result waits, so the next sample is taken in the cycle after the result beat at
// the earliest. A stalled receiver holds the result in the output register and
// the block waits. Reset clears the counts and the sequencer; no clearing pass
// is needed since only entries below the counts are ever used.
module running_median_two_heaps import rmth_pkg::*; #(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [MEDIAN_BITS-1:0] rsp_twice_median,
   output logic [COUNT_BITS-1:0]         rsp_stored_count,
   output logic                          rsp_dropped
);

   localparam int LDEPTH = (CAPACITY + 1) / 2;
   localparam int UDEPTH = (CAPACITY / 2 > 0) ? CAPACITY / 2 : 1;
   localparam int AW     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
   localparam int CW     = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]        lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   logic signed [31:0]   val_ff, val_in;       // value being sifted
   logic signed [31:0]   carry_ff, carry_in;   // old root handed to the other heap
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        n_ff, n_in;           // size of heap under work
   heap_cmd_type         cmd_ff, cmd_in;
   logic                 second_ff, second_in; // a push follows this operation
   heap_cmd_type         cmd2_ff, cmd2_in;
   logic                 drop_ff, drop_in;
   logic                 rvalid_ff, rvalid_in;
   logic signed [MEDIAN_BITS-1:0] med_ff, med_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 rdrop_ff, rdrop_in;

   logic          lwe, uwe;
   logic [AW-1:0] wa, ra_a, ra_b;
   logic [31:0]   wd;
   logic [31:0]   lra, lrb, ura, urb;
   logic signed [31:0] da, db, sample_v;
   logic [CW:0]   lch, rch;
   logic [CW-1:0] parent, best;
   logic          max_h, l_ok, r_ok, pick_l, pick_r;
   logic signed [31:0] bestv;

   rmth_heap_mem #(.DEPTH(LDEPTH), .AW(AW)) u_lower (
      .clock(clock), .wr_en(lwe), .wr_addr(wa), .wr_data(wd),
      .rd_addr_a(ra_a), .rd_addr_b(ra_b), .rd_data_a(lra), .rd_data_b(lrb));

   rmth_heap_mem #(.DEPTH(UDEPTH), .AW(AW)) u_upper (
      .clock(clock), .wr_en(uwe), .wr_addr(wa), .wr_data(wd),
      .rd_addr_a(ra_a), .rd_addr_b(ra_b), .rd_data_a(ura), .rd_data_b(urb));

   assign sample_v = 32'(signed'(req_sample[SAMPLE_BITS-1:0]));
   assign da       = cmd_ff.sel_upper ? ura : lra;
   assign db       = cmd_ff.sel_upper ? urb : lrb;
   assign max_h    = !cmd_ff.sel_upper;
   assign lch      = {pos_ff, 1'b1};
   assign rch      = {pos_ff, 1'b1} + (CW+1)'(1);
   assign parent   = (pos_ff - CW'(1)) >> 1;
   assign l_ok     = lch < {1'b0, n_ff};
   assign r_ok     = rch < {1'b0, n_ff};
   assign pick_l   = l_ok && ranks_above(da, val_ff, max_h);
   assign bestv    = pick_l ? da : val_ff;
   assign pick_r   = r_ok && ranks_above(db, bestv, max_h);
   assign best     = pick_r ? CW'(rch) : (pick_l ? CW'(lch) : pos_ff);

   assign req_ready        = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp_valid        = rvalid_ff;
   assign rsp_twice_median = med_ff;
   assign rsp_stored_count = cnt_ff;
   assign rsp_dropped      = rdrop_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid && req_ready) state_in = ST_DECIDE;
         ST_DECIDE:   state_in = drop_ff ? ST_TOPS : ST_OP_START;
         ST_OP_START: state_in = cmd_ff.replace ? ST_DN_RD : ST_UP_RD;
         ST_UP_RD:    state_in = (pos_ff == '0) ? ST_NEXT_OP : ST_UP_CMP;
         ST_UP_CMP:   state_in = ranks_above(val_ff, da, max_h) ? ST_UP_RD : ST_NEXT_OP;
         ST_DN_RD:    state_in = ST_DN_CMP;
         ST_DN_CMP:   state_in = (best == pos_ff) ? ST_NEXT_OP : ST_DN_RD;
         ST_NEXT_OP:  state_in = second_ff ? ST_OP_START : ST_TOPS;
         ST_TOPS:     state_in = ST_RESULT;
         ST_RESULT:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      lcnt_in = lcnt_ff;   ucnt_in = ucnt_ff;
      val_in = val_ff;     carry_in = carry_ff;
      pos_in = pos_ff;     n_in = n_ff;
      cmd_in = cmd_ff;     second_in = second_ff;
      cmd2_in = cmd2_ff;   drop_in = drop_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      med_in = med_ff;     cnt_in = cnt_ff;   rdrop_in = rdrop_ff;
      lwe = 1'b0;  uwe = 1'b0;
      wa = '0;     wd = val_ff;
      ra_a = '0;   ra_b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            val_in  = sample_v;
            drop_in = (CW+1)'(lcnt_ff) + (CW+1)'(ucnt_ff) >= (CW+1)'(CAPACITY);
         end
         ST_DECIDE: begin
            // Tops were read in the cycle before (address zero).
            second_in = 1'b0;
            cmd_in    = '{go: 1'b1, replace: 1'b0, sel_upper: 1'b0};
            if (lcnt_ff == '0) begin
               cmd_in.sel_upper = 1'b0;
            end else if (val_ff < signed'(lra)) begin
               if (lcnt_ff > ucnt_ff) begin
                  cmd_in    = '{go: 1'b1, replace: 1'b1, sel_upper: 1'b0};
                  second_in = 1'b1;
                  cmd2_in   = '{go: 1'b1, replace: 1'b0, sel_upper: 1'b1};
               end
            end else if (lcnt_ff > ucnt_ff) begin
               cmd_in.sel_upper = 1'b1;
            end else if (ucnt_ff != '0 && val_ff > signed'(ura)) begin
               cmd_in    = '{go: 1'b1, replace: 1'b1, sel_upper: 1'b1};
               second_in = 1'b1;
               cmd2_in   = '{go: 1'b1, replace: 1'b0, sel_upper: 1'b0};
            end
            carry_in = (val_ff < signed'(lra)) ? signed'(lra) : signed'(ura);
         end
         ST_OP_START: begin
            if (cmd_ff.replace) begin
               pos_in = '0;
               n_in   = cmd_ff.sel_upper ? ucnt_ff : lcnt_ff;
            end else begin
               pos_in = cmd_ff.sel_upper ? ucnt_ff : lcnt_ff;
               if (cmd_ff.sel_upper) ucnt_in = ucnt_ff + CW'(1);
               else                  lcnt_in = lcnt_ff + CW'(1);
            end
         end
         ST_UP_RD: begin
            // Write the hole, read the parent.
            wa  = AW'(pos_ff);
            lwe = !cmd_ff.sel_upper;
            uwe = cmd_ff.sel_upper;
            ra_a = AW'(parent);
         end
         ST_UP_CMP: begin
            if (ranks_above(val_ff, da, max_h)) begin
               wa  = AW'(pos_ff);
               wd  = da;
               lwe = !cmd_ff.sel_upper;
               uwe = cmd_ff.sel_upper;
               pos_in = parent;
            end
         end
         ST_DN_RD: begin
            ra_a = AW'(lch);
            ra_b = AW'(rch);
         end
         ST_DN_CMP: begin
            wa  = AW'(pos_ff);
            wd  = (best == pos_ff) ? val_ff : (pick_r ? db : da);
            lwe = !cmd_ff.sel_upper;
            uwe = cmd_ff.sel_upper;
            pos_in = best;
         end
         ST_NEXT_OP: begin
            if (second_ff) begin
               cmd_in    = cmd2_ff;
               second_in = 1'b0;
               val_in    = carry_ff;
            end
         end
         ST_TOPS: ;
         ST_RESULT: begin
            rvalid_in = 1'b1;
            rdrop_in  = drop_ff;
            cnt_in    = COUNT_BITS'(lcnt_ff) + COUNT_BITS'(ucnt_ff);
            if (lcnt_ff == '0)
               med_in = '0;
            else if (lcnt_ff == ucnt_ff)
               med_in = MEDIAN_BITS'(signed'(lra)) + MEDIAN_BITS'(signed'(ura));
            else
               med_in = MEDIAN_BITS'(signed'(lra)) <<< 1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         lcnt_ff   <= '0;
         ucnt_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         lcnt_ff   <= lcnt_in;
         ucnt_ff   <= ucnt_in;
         rvalid_ff <= rvalid_in;
      end
      val_ff    <= val_in;
      carry_ff  <= carry_in;
      pos_ff    <= pos_in;
      n_ff      <= n_in;
      cmd_ff    <= cmd_in;
      second_ff <= second_in;
      cmd2_ff   <= cmd2_in;
      drop_ff   <= drop_in;
      med_ff    <= med_in;
      cnt_ff    <= cnt_in;
      rdrop_ff  <= rdrop_in;
   end

endmodule

// File: src/rmth_checker.sv
module rmth_checker import rmth_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [MEDIAN_BITS-1:0] rsp_twice_median,
   input logic [COUNT_BITS-1:0]         rsp_stored_count,
   input logic                          rsp_dropped
);

   // A held result beat must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_twice_median)
         && $stable(rsp_stored_count) && $stable(rsp_dropped))
      else $error("result beat changed while stalled");

   // No new sample is taken while a result waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while result pending");

   // An accepted sample takes the block out of ready.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after accept");

   // A dropped beat always reports a non-empty store.
   a_drop_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_stored_count != '0)
      else $error("drop with empty store");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_twice_median(rsp_twice_median),
   .rsp_stored_count(rsp_stored_count),
   .rsp_dropped(rsp_dropped));

// File: tb/sv/running_median_two_heaps_test.sv
`timescale 1ns / 100ps

module running_median_two_heaps_test import rmth_pkg::*;;

   localparam int CAP        = CAPACITY_DEF;
   localparam int LOW_DEPTH  = (CAP + 1) / 2;
   localparam int HIGH_DEPTH = CAP / 2;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic signed [MEDIAN_BITS-1:0] twice_median;
      logic [COUNT_BITS-1:0]         stored_count;
      logic                          dropped;
   } median_result_type;

   // One directed row: the sample, and optionally a result typed in by hand.
   typedef struct {
      logic signed [31:0]            sample;
      logic                          fixed;
      logic signed [MEDIAN_BITS-1:0] twice_median;
      logic [COUNT_BITS-1:0]         stored_count;
   } directed_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [31:0]            req_sample;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [MEDIAN_BITS-1:0] rsp_twice_median;
   logic [COUNT_BITS-1:0]         rsp_stored_count;
   logic                          rsp_dropped;

   running_median_two_heaps DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_twice_median (rsp_twice_median),
      .rsp_stored_count (rsp_stored_count),
      .rsp_dropped      (rsp_dropped)
   );

   logic signed [31:0] low_heap [LOW_DEPTH];
   logic signed [31:0] high_heap [HIGH_DEPTH];
   int                 low_count;
   int                 high_count;

   median_result_type pending_medians [$];
   int                mismatch_count;
   int                idle_cycles;
   bit                calm_phase;
   bit                hold_receiver;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b, bit is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

   task automatic push_low(logic signed [31:0] v);
      int pos;
      int parent;
      logic signed [31:0] t;
      pos = low_count;
      low_heap[pos] = v;
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (!outranks(low_heap[pos], low_heap[parent], 1'b1)) break;
         t = low_heap[pos]; low_heap[pos] = low_heap[parent]; low_heap[parent] = t;
         pos = parent;
      end
      low_count++;
   endtask

   task automatic push_high(logic signed [31:0] v);
      int pos;
      int parent;
      logic signed [31:0] t;
      pos = high_count;
      high_heap[pos] = v;
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (!outranks(high_heap[pos], high_heap[parent], 1'b0)) break;
         t = high_heap[pos]; high_heap[pos] = high_heap[parent]; high_heap[parent] = t;
         pos = parent;
      end
      high_count++;
   endtask

   // Replaces the root of one heap and sifts down; returns the old root.
   function automatic logic signed [31:0] swap_root(bit is_low, logic signed [31:0] v);
      logic signed [31:0] old_root;
      logic signed [31:0] t;
      int pos;
      int l;
      int r;
      int best;
      int n;
      n = is_low ? low_count : high_count;
      old_root = is_low ? low_heap[0] : high_heap[0];
      if (is_low) low_heap[0] = v; else high_heap[0] = v;
      pos = 0;
      forever begin
         l = 2 * pos + 1;
         r = l + 1;
         best = pos;
         if (is_low) begin
            if (l < n && low_heap[l] > low_heap[best]) best = l;
            if (r < n && low_heap[r] > low_heap[best]) best = r;
            if (best == pos) break;
            t = low_heap[pos]; low_heap[pos] = low_heap[best]; low_heap[best] = t;
         end else begin
            if (l < n && high_heap[l] < high_heap[best]) best = l;
            if (r < n && high_heap[r] < high_heap[best]) best = r;
            if (best == pos) break;
            t = high_heap[pos]; high_heap[pos] = high_heap[best]; high_heap[best] = t;
         end
         pos = best;
      end
      return old_root;
   endfunction

   task automatic predict_median(logic signed [31:0] v, output median_result_type res);
      logic signed [31:0] top;
      logic signed [63:0] sum;
      res.dropped = 1'b0;
      if (low_count + high_count >= CAP) begin
         res.dropped = 1'b1;
      end else if (low_count == 0) begin
         push_low(v);
      end else if (v < low_heap[0]) begin
         if (low_count > high_count) begin
            top = swap_root(1'b1, v);
            push_high(top);
         end else begin
            push_low(v);
         end
      end else if (low_count > high_count) begin
         push_high(v);
      end else if (high_count == 0 || v <= high_heap[0]) begin
         push_low(v);
      end else begin
         top = swap_root(1'b0, v);
         push_low(top);
      end
      sum = 0;
      if (low_count > 0) begin
         if (low_count == high_count) sum = 64'(low_heap[0]) + 64'(high_heap[0]);
         else sum = 2 * 64'(low_heap[0]);
      end
      res.twice_median = sum[MEDIAN_BITS-1:0];
      res.stored_count = COUNT_BITS'(low_count + high_count);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Result checking against the oldest expectation.
   always @(posedge clock) begin
      median_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_medians.size() == 0) begin
            report_mismatch("unexpected beat, median", 64'(rsp_twice_median), 0);
         end else begin
            want = pending_medians.pop_front();
            if (rsp_twice_median !== want.twice_median)
               report_mismatch("twice_median", 64'(rsp_twice_median), 64'(want.twice_median));
            if (rsp_stored_count !== want.stored_count)
               report_mismatch("stored_count", 64'(rsp_stored_count), 64'(want.stored_count));
            if (rsp_dropped !== want.dropped)
               report_mismatch("dropped", 64'(rsp_dropped), 64'(want.dropped));
         end
      end
   end

   // Receiver: random stall bursts, a long hold-off on request, none at the end.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_receiver) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("running_median_two_heaps: mismatch");
         $finish;
      end
   end

   // Offers one sample and waits for its acceptance; records the expectation.
   // Valid stays high after the beat so that a following sample goes out
   // back to back; a gap or a drain takes it low.
   task automatic send_sample(logic signed [31:0] v, bit with_gaps);
      median_result_type res;
      if (with_gaps && !calm_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (!req_ready);
      predict_median(v, res);
      pending_medians = {pending_medians, res};
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_sample(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed(32'($urandom_range(0, 40))) - 20;
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed(32'($urandom_range(0, 2000))) - 1000;
      endcase
   endfunction

   directed_row_type directed_rows [] = '{
      '{32'sh80000000, 1'b1, -33'sh100000000, 11'd1},
      '{32'sh80000000, 1'b1, -33'sh100000000, 11'd2},
      '{32'sh7fffffff, 1'b1, -33'sh100000000, 11'd3},
      '{32'sh7fffffff, 1'b1, -33'sd1, 11'd4},
      '{32'sh7fffffff, 1'b1, 33'sh0fffffffe, 11'd5},
      '{32'sh7fffffff, 1'b1, 33'sh0fffffffe, 11'd6},
      '{32'sd0, 1'b0, '0, '0},
      '{-32'sd1, 1'b0, '0, '0},
      '{32'sd1, 1'b0, '0, '0},
      '{32'sd1, 1'b0, '0, '0},
      '{32'sh55555555, 1'b0, '0, '0},
      '{32'shaaaaaaaa, 1'b0, '0, '0},
      '{-32'sd5, 1'b0, '0, '0},
      '{32'sd7, 1'b0, '0, '0},
      '{32'sd0, 1'b0, '0, '0}
   };

   initial begin
      median_result_type res;
      int mode;
      int run_len;
      mismatch_count = 0;
      calm_phase     = 1'b0;
      hold_receiver  = 1'b0;
      req_valid      = 1'b0;
      req_sample     = '0;
      low_count      = 0;
      high_count     = 0;
      reset          = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].sample, 1'b1);
         if (directed_rows[i].fixed) begin
            res = pending_medians[$];
            if (res.twice_median !== directed_rows[i].twice_median ||
                res.stored_count !== directed_rows[i].stored_count)
               report_mismatch("directed row expectation", 64'(i), 0);
            pending_medians[$].twice_median = directed_rows[i].twice_median;
            pending_medians[$].stored_count = directed_rows[i].stored_count;
         end
      end

      // Sender pauses until every result is in.
      drain_results();

      // The receiver holds off while samples keep coming, so the input stalls.
      hold_receiver = 1'b1;
      repeat (3) send_sample(random_sample(3), 1'b0);
      hold_receiver = 1'b0;

      // Fill the store past capacity so that drops are seen, in runs of one style.
      while (low_count + high_count < CAP) begin
         mode    = $urandom_range(0, 3);
         run_len = $urandom_range(5, 40);
         repeat (run_len) send_sample(random_sample(mode), 1'b1);
      end
      repeat (40) send_sample(random_sample($urandom_range(0, 3)), 1'b1);

      calm_phase = 1'b1;
      repeat (60) send_sample(random_sample(0), 1'b0);

      drain_results();
      if (mismatch_count == 0) begin
         $display("running_median_two_heaps: match");
      end else begin
         $display("running_median_two_heaps: mismatch");
      end
      $finish;
   end

endmodule
